[src/assert_macros.svh]
// Assertion macros used by the accumulator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PLAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PLAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/plac_pkg.sv]
// Types, codes and constants of the path length accumulator.
`default_nettype none
package plac_pkg;

    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_ARC  = 2'd1;
    localparam logic [1:0] CMD_BACK = 2'd2;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    localparam int SQRT_STEPS   = 33;
    localparam int DIV_STEPS    = 64;
    localparam int CORDIC_STEPS = 31;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_SQX        = 4'd2;
    localparam logic [3:0] OP_SQY        = 4'd3;
    localparam logic [3:0] OP_SQRT_STEP  = 4'd4;
    localparam logic [3:0] OP_CHK        = 4'd5;
    localparam logic [3:0] OP_DIV_INIT   = 4'd6;
    localparam logic [3:0] OP_DIV_STEP   = 4'd7;
    localparam logic [3:0] OP_SSQ        = 4'd8;
    localparam logic [3:0] OP_CORD_INIT  = 4'd9;
    localparam logic [3:0] OP_CORD_STEP  = 4'd10;
    localparam logic [3:0] OP_MUL        = 4'd11;
    localparam logic [3:0] OP_FIN        = 4'd12;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [31:0]        radius;
    } t_in;

    typedef struct packed {
        logic [47:0] total_distance;
        logic        arc_error;
        logic        saturated;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic mov;       // line or arc command captured
        logic line;      // line command captured
        logic arc_skip;  // arc rejected or zero chord; valid in the check step
    } t_dp_sts;

    // Arctangent of 2^-i, Q2.30, truncated.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[src/plac_ctrl.sv]
// Controller state machine that sequences the shared datapath.
`default_nettype none
module plac_ctrl
    import plac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SSQ   = 4'd7;
    localparam logic [3:0] S_SQRT2 = 4'd8;
    localparam logic [3:0] S_CINIT = 4'd9;
    localparam logic [3:0] S_CORD  = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
    localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_valid, n_valid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt + 6'd1;
        n_valid   = r_valid && i_out_stall;
        o_cmd.op  = OP_NONE;
        o_cmd.idx = r_cnt[4:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SQX;
                end
            end
            S_SQX: begin
                if (i_sts.mov) begin
                    o_cmd.op = OP_SQX;
                    n_state  = S_SQY;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.op = OP_CHK;
                n_state  = (i_sts.line || i_sts.arc_skip) ? S_FIN : S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SSQ;
                end
            end
            S_SSQ: begin
                o_cmd.op = OP_SSQ;
                n_cnt    = '0;
                n_state  = S_SQRT2;
            end
            S_SQRT2: begin
                o_cmd.op = OP_SQRT_STEP;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CORD_INIT;
                n_cnt    = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                o_cmd.op = OP_CORD_STEP;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // The result register is free or is being emptied this cycle.
                if (!r_valid || !i_out_stall) begin
                    o_cmd.op = OP_FIN;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

endmodule
`default_nettype wire

[src/plac_dp.sv]
// Datapath: position state, shared multiplier, square root, divider and CORDIC.
`default_nettype none
module plac_dp
    import plac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire t_in         i_in,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output t_dp_sts          o_sts,
    output t_out             o_out
);

    logic [1:0]         r_cmd;
    logic [31:0]        r_tx, r_ty, r_r;
    logic [31:0]        r_cx, r_cy, r_px, r_py;
    logic [47:0]        r_last, r_sum;
    logic [32:0]        r_mx, r_my;
    logic [65:0]        r_rad;
    logic [35:0]        r_rem;
    logic [32:0]        r_root;
    logic [32:0]        r_chord;
    logic               r_reject, r_zero;
    logic [63:0]        r_dvd;
    logic [31:0]        r_drem;
    logic [32:0]        r_quo;
    logic signed [35:0] r_vx, r_vy;
    logic signed [32:0] r_z;
    logic [34:0]        r_step;
    t_out               r_out;

    // Shared multiplier.
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;

    always_comb begin
        case (i_cmd.op)
            OP_SQX:  begin mul_a = r_mx;                mul_b = r_mx;                end
            OP_SQY:  begin mul_a = r_my;                mul_b = r_my;                end
            OP_SSQ:  begin mul_a = {1'b0, r_quo[31:0]}; mul_b = {1'b0, r_quo[31:0]}; end
            OP_MUL:  begin
                mul_a = {1'b0, r_r};
                mul_b = r_z[32] ? 33'd0 : {1'b0, r_z[31:0]};
            end
            default: begin mul_a = r_mx;                mul_b = r_my;                end
        endcase
    end

    assign prod = {33'd0, mul_a} * {33'd0, mul_b};

    // Signed coordinate differences of the incoming item from the current position.
    logic signed [32:0] dx, dy;
    assign dx = 33'(signed'(i_in.target_x)) - 33'(signed'(r_cx));
    assign dy = 33'(signed'(i_in.target_y)) - 33'(signed'(r_cy));

    // One square root digit.
    logic [35:0] sq_rem_sh, sq_trial;
    logic        sq_ge;
    assign sq_rem_sh = {r_rem[33:0], r_rad[65:64]};
    assign sq_trial  = {1'b0, r_root, 2'b01};
    assign sq_ge     = (sq_rem_sh >= sq_trial);

    // One quotient bit.
    logic [32:0] dv_sh;
    logic        dv_ge;
    assign dv_sh = {r_drem, r_dvd[63]};
    assign dv_ge = (dv_sh >= {1'b0, r_r});

    // One CORDIC rotation.
    logic signed [35:0] vy_sh, vx_sh;
    logic signed [32:0] atn;
    assign vy_sh = r_vy >>> i_cmd.idx;
    assign vx_sh = r_vx >>> i_cmd.idx;
    assign atn   = 33'(signed'({1'b0, atan_q30(i_cmd.idx)}));

    // Arc acceptance on the chord just computed.
    logic reject_now, zero_now;
    assign reject_now = (r_cmd == CMD_ARC) && ((r_r == 32'd0) || ({r_r, 1'b0} < r_root));
    assign zero_now   = (r_root == 33'd0);

    // Final update.
    logic [47:0] step, n_sum;
    logic [48:0] sum_wide;
    logic        do_move, do_back;

    always_comb begin
        if (r_cmd == CMD_LINE) begin
            step = {15'd0, r_chord};
        end else if (r_zero) begin
            step = '0;
        end else begin
            step = {13'd0, r_step};
        end
    end

    assign do_move  = (r_cmd == CMD_LINE) || ((r_cmd == CMD_ARC) && !r_reject);
    assign do_back  = (r_cmd == CMD_BACK);
    assign sum_wide = {1'b0, r_sum} + {1'b0, (do_back ? r_last : step)};

    always_comb begin
        if (do_move || do_back) begin
            n_sum = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
        end else begin
            n_sum = r_sum;
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_last <= '0;
            r_sum  <= '0;
        end else if (i_cmd.op == OP_FIN) begin
            r_sum <= n_sum;
            if (do_move) begin
                r_last <= step;
                r_px   <= r_cx;
                r_py   <= r_cy;
                r_cx   <= r_tx;
                r_cy   <= r_ty;
            end else if (do_back) begin
                r_px <= r_cx;
                r_py <= r_cy;
                r_cx <= r_px;
                r_cy <= r_py;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx) begin
                r_cy <= i_cfg_data;
            end else begin
                r_cx <= i_cfg_data;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= i_in.command;
                r_tx  <= i_in.target_x;
                r_ty  <= i_in.target_y;
                r_r   <= i_in.radius;
                r_mx  <= dx[32] ? 33'(-dx) : 33'(dx);
                r_my  <= dy[32] ? 33'(-dy) : 33'(dy);
            end
            OP_SQX: begin
                r_rad <= prod;
            end
            OP_SQY: begin
                r_rad  <= r_rad + prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                r_rad <= {r_rad[63:0], 2'b00};
                if (sq_ge) begin
                    r_rem  <= sq_rem_sh - sq_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem_sh;
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            OP_CHK: begin
                r_chord  <= r_root;
                r_reject <= reject_now;
                r_zero   <= zero_now;
            end
            OP_DIV_INIT: begin
                r_dvd  <= {r_chord, 31'd0};
                r_drem <= '0;
                r_quo  <= '0;
            end
            OP_DIV_STEP: begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                if (dv_ge) begin
                    r_drem <= 32'(dv_sh - {1'b0, r_r});
                    r_quo  <= {r_quo[31:0], 1'b1};
                end else begin
                    r_drem <= dv_sh[31:0];
                    r_quo  <= {r_quo[31:0], 1'b0};
                end
            end
            OP_SSQ: begin
                // A ratio of one or more leaves no cosine term.
                r_rad  <= r_quo[32] ? 66'd0 : ({2'b01, 64'd0} - prod);
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_CORD_INIT: begin
                r_vx <= 36'(r_root);
                r_vy <= 36'(r_quo);
                r_z  <= '0;
            end
            OP_CORD_STEP: begin
                if (r_vy > 36'sd0) begin
                    r_vx <= r_vx + vy_sh;
                    r_vy <= r_vy - vx_sh;
                    r_z  <= r_z + atn;
                end else begin
                    r_vx <= r_vx - vy_sh;
                    r_vy <= r_vy + vx_sh;
                    r_z  <= r_z - atn;
                end
            end
            OP_MUL: begin
                r_step <= prod[63:29];
            end
            OP_FIN: begin
                r_out.total_distance <= n_sum;
                r_out.arc_error      <= (r_cmd == CMD_ARC) && r_reject;
                r_out.saturated      <= (n_sum == SUM_MAX);
            end
            default: begin
            end
        endcase
    end

    assign o_sts.mov      = (r_cmd == CMD_LINE) || (r_cmd == CMD_ARC);
    assign o_sts.line     = (r_cmd == CMD_LINE);
    assign o_sts.arc_skip = reject_now || zero_now;
    assign o_out          = r_out;

endmodule
`default_nettype wire

[src/path_length_accumulator_core.sv]
// Backtrack and unused commands go straight to the final update; lines and arcs first square
// and take the square root of the distance; one item is worked on at a time.
// The arc path is set by the 33-step square root (run twice), the 64-step divider
// and the 31-step CORDIC, which take turns on one shared datapath.
// A result waits in an output register; new input can be taken the cycle after it is written.
// Synchronous active-low reset clears position, sums and control; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module path_length_accumulator_core
    import plac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    plac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    plac_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (dp_sts),
        .o_out      (o_out)
    );

    `PLAC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "block not busy after input transfer")
    `PLAC_ASSERT(a_sat_flag, i_clk, i_rst_n, o_out_valid |-> (o_out.saturated == (o_out.total_distance == SUM_MAX)), "saturated flag disagrees with total")
    `PLAC_ASSERT(a_fin_when_free, i_clk, i_rst_n, (dp_cmd.op == OP_FIN) |-> (!o_out_valid || !i_out_stall), "result written over a pending result")

endmodule
`default_nettype wire
